/* src/mau_pkg.sv */
// Shared constants and command codes for the modular arithmetic unit.
package mau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 2;
  localparam int IN_TDATA_W    = 72;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [31:0] MOD_RESET = 32'd998244353;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

  localparam logic [0:0] REG_MODULUS = 1'd0;

endpackage

/* src/mau_regs.sv */
// APB configuration register holding the modulus.
module mau_regs #(
  parameter int WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [mau_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mau_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mau_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic [WORD_BITS-1:0]           modulus
);
  import mau_pkg::*;

  logic [WORD_BITS-1:0] modulus_r;
  logic                 wr_en;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_ADDR_W-1 -: 1] == REG_MODULUS);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_W'(modulus_r);
  assign modulus    = modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET[WORD_BITS-1:0];
    end else if (wr_en) begin
      modulus_r <= cfg_pwdata[WORD_BITS-1:0];
    end
  end

endmodule

/* src/mau_div.sv */
// Restoring shift-subtract divider, one quotient bit per cycle.
module mau_div #(
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     long_run,
  input  logic [2*WORD_BITS-1:0]   dividend,
  input  logic [WORD_BITS-1:0]     divisor,
  output logic                     done,
  output logic [WORD_BITS-1:0]     quotient,
  output logic [WORD_BITS-1:0]     remainder
);
  import mau_pkg::*;

  localparam int CNT_W = $clog2(2 * WORD_BITS + 1);

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [2*WORD_BITS-1:0] q_r, q_nxt;
  logic [WORD_BITS-1:0]   rem_r, rem_nxt;
  logic [WORD_BITS-1:0]   div_r, div_nxt;
  logic [WORD_BITS:0]     rem_sh;
  logic [WORD_BITS:0]     rem_sub;
  logic                   ge;

  assign rem_sh  = {rem_r, q_r[2*WORD_BITS-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      cnt_nxt = long_run ? CNT_W'(2 * WORD_BITS) : CNT_W'(WORD_BITS);
      q_nxt   = long_run ? dividend : {dividend[WORD_BITS-1:0], {WORD_BITS{1'b0}}};
      rem_nxt = '0;
      div_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
      q_nxt    = {q_r[2*WORD_BITS-2:0], ge};
      rem_nxt  = ge ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r[WORD_BITS-1:0];
  assign remainder = rem_r;

endmodule

/* src/modular_arithmetic_unit.sv */
// Top level: sequencer, shared multiplier and output register of the unit.
// Add/subtract reduce an operand with the divider only when it is not below the modulus;
// multiply reduces its product with the divider; divide runs extended-Euclid rounds, each a
// divider pass and a multiply (at most 46 rounds at 32 bits), then multiplies by the inverse.
// in_tready is high only when idle, so no new transaction is taken while one is in flight.
// Reset: synchronous active-low rst_n clears control state, modulus to 998244353.
module modular_arithmetic_unit #(
  parameter int WORD_BITS = mau_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mau_pkg::IN_TDATA_W-1:0] in_tdata,   // cmd[1:0], operand_a[33:2], operand_b[65:34]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mau_pkg::DATA_W-1:0]     out_tdata,  // result[31:0]
  output logic                           out_tuser,  // not_invertible[0]
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [mau_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mau_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mau_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import mau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CW = W + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RED_A = 4'd2;
  localparam logic [3:0] S_CHK_B = 4'd3;
  localparam logic [3:0] S_RED_B = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_MRED  = 4'd7;
  localparam logic [3:0] S_MWAIT = 4'd8;
  localparam logic [3:0] S_EUC   = 4'd9;
  localparam logic [3:0] S_EDIV  = 4'd10;
  localparam logic [3:0] S_EMUL  = 4'd11;
  localparam logic [3:0] S_ESTEP = 4'd12;
  localparam logic [3:0] S_INV   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [W-1:0] modulus;

  logic [3:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [W-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]      ea_r, ea_nxt, eb_r, eb_nxt;
  logic [CW-1:0]     u_r, u_nxt, v_r, v_nxt;
  logic [2*W+1:0]    prod_r, prod_nxt;
  logic [W-1:0]      res_r, res_nxt;
  logic              flag_r, flag_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;

  logic              div_start, div_long, div_done;
  logic [2*W-1:0]    div_dividend;
  logic [W-1:0]      div_divisor, div_quot, div_rem;

  logic [W-1:0]      mul_x;
  logic [CW-1:0]     mul_y;
  logic [W:0]        sum, sum_red;
  logic [CW-1:0]     u_fix;

  mau_regs #(.WORD_BITS(W)) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .modulus     (modulus)
  );

  mau_div #(.WORD_BITS(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .long_run  (div_long),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign sum     = {1'b0, a_r} + {1'b0, (cmd_r == CMD_SUB) ? (modulus - b_r) : b_r};
  assign sum_red = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;
  assign u_fix   = u_r[CW-1] ? (u_r + {2'b00, modulus}) : u_r;

  always_comb begin
    mul_x = a_r;
    mul_y = {2'b00, b_r};
    if (state_r == S_EMUL) begin
      mul_x = div_quot;
      mul_y = v_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    div_start     = 1'b0;
    div_long      = 1'b0;
    div_dividend  = {{W{1'b0}}, a_r};
    div_divisor   = modulus;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tdata[CMD_W-1:0];
          a_nxt     = in_tdata[CMD_W +: W];
          b_nxt     = in_tdata[CMD_W+DATA_W +: W];
          flag_nxt  = 1'b0;
          res_nxt   = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (modulus[W-1:1] == '0) begin
          state_nxt = S_DONE;
        end else begin
          case (cmd_r)
            CMD_ADD, CMD_SUB: begin
              if (a_r >= modulus) begin
                div_start = 1'b1;
                state_nxt = S_RED_A;
              end else begin
                state_nxt = S_CHK_B;
              end
            end
            CMD_MUL: state_nxt = S_MUL;
            default: begin
              ea_nxt    = b_r;
              eb_nxt    = modulus;
              u_nxt     = CW'(1);
              v_nxt     = '0;
              state_nxt = S_EUC;
            end
          endcase
        end
      end
      S_RED_A: begin
        if (div_done) begin
          a_nxt     = div_rem;
          state_nxt = S_CHK_B;
        end
      end
      S_CHK_B: begin
        div_dividend = {{W{1'b0}}, b_r};
        if (b_r >= modulus) begin
          div_start = 1'b1;
          state_nxt = S_RED_B;
        end else begin
          state_nxt = S_ADD;
        end
      end
      S_RED_B: begin
        if (div_done) begin
          b_nxt     = div_rem;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        res_nxt   = sum_red[W-1:0];
        state_nxt = S_DONE;
      end
      S_MUL: begin
        prod_nxt  = {{(W+2){1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
        state_nxt = S_MRED;
      end
      S_MRED: begin
        div_start    = 1'b1;
        div_long     = 1'b1;
        div_dividend = prod_r[2*W-1:0];
        state_nxt    = S_MWAIT;
      end
      S_MWAIT: begin
        if (div_done) begin
          res_nxt   = div_rem;
          state_nxt = S_DONE;
        end
      end
      S_EUC: begin
        div_dividend = {{W{1'b0}}, ea_r};
        div_divisor  = eb_r;
        if (eb_r == '0) begin
          if (ea_r == W'(1)) begin
            state_nxt = S_INV;
          end else begin
            res_nxt   = '0;
            flag_nxt  = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_EDIV;
        end
      end
      S_EDIV: begin
        if (div_done) begin
          state_nxt = S_EMUL;
        end
      end
      S_EMUL: begin
        prod_nxt  = {{(W+2){1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
        state_nxt = S_ESTEP;
      end
      S_ESTEP: begin
        ea_nxt    = eb_r;
        eb_nxt    = div_rem;
        u_nxt     = v_r;
        v_nxt     = u_r - prod_r[CW-1:0];
        state_nxt = S_EUC;
      end
      S_INV: begin
        b_nxt     = u_fix[W-1:0];
        state_nxt = S_MUL;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = DATA_W'(res_r);
          out_user_nxt  = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

/* src/mau_chk.sv */
// Port-level checker for the modular arithmetic unit and its bind.
module mau_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mau_pkg::DATA_W-1:0]     out_tdata,
  input logic                           out_tuser
);
  import mau_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous transaction in flight");

  a_flag_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("not_invertible raised with non-zero result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output transaction changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind modular_arithmetic_unit mau_chk u_mau_chk (.*);

/* bench/tb.sv */
// Self-checking bench for the modular arithmetic unit: stream traffic over several moduli.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mau_pkg::*;

  localparam int          CLK_PERIOD  = 10;
  localparam int          CYCLE_LIMIT = 12_000_000;
  localparam int          DRAIN_WAIT  = 2000;
  localparam logic [CFG_ADDR_W-1:0] MOD_ADDR = CFG_ADDR_W'({REG_MODULUS, 2'b00});

  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN} ready_mode_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] residue;
    logic              not_inv;
  } residue_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata    = '0;   // cmd[1:0], operand_a[33:2], operand_b[65:34]
  logic                  out_tvalid;
  logic                  out_tready  = 1'b1;
  logic [DATA_W-1:0]     out_tdata;          // result[31:0]
  logic                  out_tuser;          // not_invertible[0]
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  residue_t          residue_q[$];
  logic [DATA_W-1:0] modulus_model = MOD_RESET;
  int                mismatches    = 0;
  int                cycles        = 0;
  ready_mode_t       ready_mode    = READY_ALWAYS;
  int                mode_left     = 0;
  logic [7:0]        pattern_count = '0;
  logic [CMD_W-1:0]  all_cmds [4]  = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};

  modular_arithmetic_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Extended Euclid; zero means no inverse exists.
  function automatic longint unsigned inverse_mod(longint unsigned x, longint unsigned m);
    longint unsigned g0, g1, g2, q;
    longint          s0, s1, s2;
    g0 = x;
    g1 = m;
    s0 = 1;
    s1 = 0;
    while (g1 != 0) begin
      q  = g0 / g1;
      g2 = g0 - q * g1;
      s2 = s0 - longint'(q) * s1;
      g0 = g1;
      g1 = g2;
      s0 = s1;
      s1 = s2;
    end
    if (g0 != 1) return 0;
    if (s0 < 0) s0 = s0 + longint'(m);
    return $unsigned(s0) % m;
  endfunction

  function automatic residue_t predict_residue(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] lhs,
                                               logic [DATA_W-1:0] rhs, logic [DATA_W-1:0] m_val);
    residue_t        e;
    longint unsigned m, a, b, r, inv;
    e.cmd     = cmd;
    e.lhs     = lhs;
    e.rhs     = rhs;
    e.not_inv = 1'b0;
    m = m_val;
    a = lhs;
    b = rhs;
    r = 0;
    if (m >= 2) begin
      a = a % m;
      b = b % m;
      case (cmd)
        CMD_ADD: begin
          r = a + b;
          if (r >= m) r = r - m;
        end
        CMD_SUB: begin
          r = a + (m - b);
          if (r >= m) r = r - m;
        end
        CMD_MUL: r = (a * b) % m;
        default: begin
          inv = inverse_mod(b, m);
          if (inv == 0) e.not_inv = 1'b1;
          else r = (a * inv) % m;
        end
      endcase
    end
    e.residue = DATA_W'(r);
    return e;
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand(logic [DATA_W-1:0] m_val);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return m_val - 1;
      3:       return m_val + DATA_W'($urandom_range(0, 1));
      4, 5, 6: return (m_val == 0) ? DATA_W'($urandom) : DATA_W'($urandom % m_val);
      7:       return DATA_W'($urandom_range(0, 15));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d (0x%08h) got %0d (0x%08h)", what, want, want, got, got);
  endtask

  // Compare each accepted result; record each accepted transaction's expectation.
  always @(posedge clk) begin
    residue_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (residue_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_tdata);
      end else begin
        e = residue_q.pop_front();
        if (out_tdata !== e.residue)
          report_mismatch($sformatf("result cmd=%0d a=0x%08h b=0x%08h", e.cmd, e.lhs, e.rhs),
                          e.residue, out_tdata);
        if (out_tuser !== e.not_inv)
          report_mismatch($sformatf("not_invertible cmd=%0d a=0x%08h b=0x%08h", e.cmd, e.lhs,
                                    e.rhs), DATA_W'(e.not_inv), DATA_W'(out_tuser));
      end
    end
    if (rst_n && in_tvalid && in_tready)
      residue_q.push_back(predict_residue(in_tdata[1:0], in_tdata[33:2], in_tdata[65:34],
                                          modulus_model));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: switch to a new random stall style whenever the mode counter runs out.
  always @(negedge clk) begin
    pattern_count <= pattern_count + 1'b1;
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(50, 600);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:      out_tready <= (pattern_count[4:2] != 3'b000);
    endcase
  end

  task automatic send_op(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] lhs, logic [DATA_W-1:0] rhs);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, rhs, lhs, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_off(int gap);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain_results();
    while (residue_q.size() != 0) @(posedge clk);
  endtask

  task automatic read_modulus_check(logic [DATA_W-1:0] want);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= MOD_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) report_mismatch("modulus readback", want, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_modulus(logic [DATA_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= MOD_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    modulus_model = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    read_modulus_check(value);
  endtask

  task automatic test_corner_operands();
    logic [DATA_W-1:0] m;
    m = modulus_model;
    read_modulus_check(MOD_RESET);
    foreach (all_cmds[i]) begin
      send_op(all_cmds[i], '0, '0);
      send_op(all_cmds[i], '1, '1);
      send_op(all_cmds[i], m - 1, m - 1);
    end
    send_op(CMD_DIV, 32'd5, '0);
    send_op(CMD_DIV, m - 1, m);
    send_op(CMD_DIV, 32'd7, 32'd1);
    send_op(CMD_SUB, '0, m - 1);
    send_op(CMD_ADD, m - 1, 32'd1);
    hold_off(0);
  endtask

  task automatic test_degenerate_moduli();
    write_modulus(32'd1);
    foreach (all_cmds[i]) send_op(all_cmds[i], '1, 32'd3);
    hold_off(0);
    write_modulus(32'd0);
    foreach (all_cmds[i]) send_op(all_cmds[i], 32'd9, '1);
    hold_off(0);
  endtask

  task automatic test_random_residues(logic [DATA_W-1:0] m_val, int count);
    int burst;
    write_modulus(m_val);
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        send_op(CMD_W'($urandom_range(0, 3)), pick_operand(m_val), pick_operand(m_val));
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(0, 40));
    end
    hold_off(0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_operands();
    test_degenerate_moduli();
    test_random_residues(MOD_RESET, 200);
    test_random_residues(32'd2, 120);
    test_random_residues(32'hFFFF_FFFF, 200);
    test_random_residues(32'd4294967291, 200);
    test_random_residues(32'd12, 120);
    test_random_residues(DATA_W'($urandom) | 32'd1, 200);
    test_random_residues({31'($urandom_range(1, 32'h7FFF_FFFF)), 1'b0}, 150);
    test_random_residues(DATA_W'($urandom_range(2, 1000)), 110);
    test_random_residues(32'h8000_0000, 100);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && residue_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mau_pkg.sv
src/mau_regs.sv
src/mau_div.sv
src/modular_arithmetic_unit.sv
src/mau_chk.sv
bench/tb.sv
